/* rtl/bptt_pkg.sv */
// Shared types and constants for the bivariate polynomial term table.
package bptt_pkg;

    localparam int MAX_TERMS = 16;
    localparam int MAX_POWER = 15;
    localparam int IDX_W     = $clog2(MAX_TERMS);
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int POW_W     = 4;
    localparam int COEF_W    = 16;
    localparam int VAL_W     = 16;
    localparam int SUM_W     = 32;
    localparam int POS_W     = 5;
    localparam int CMD_W     = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVAL   = 2'd2;

    // index register operations
    localparam logic [2:0] IDX_HOLD  = 3'd0;
    localparam logic [2:0] IDX_COUNT = 3'd1;
    localparam logic [2:0] IDX_POS   = 3'd2;
    localparam logic [2:0] IDX_ZERO  = 3'd3;
    localparam logic [2:0] IDX_DEC   = 3'd4;
    localparam logic [2:0] IDX_INC   = 3'd5;

    // table read address select
    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_PREV = 2'd1;
    localparam logic [1:0] RD_NEXT = 2'd2;
    localparam logic [1:0] RD_CUR  = 2'd3;

    // table write select
    localparam logic [1:0] WR_NONE  = 2'd0;
    localparam logic [1:0] WR_MOVED = 2'd1;
    localparam logic [1:0] WR_NEW   = 2'd2;

    typedef struct packed {
        logic                     neg;
        logic signed [COEF_W-1:0] coef;
        logic [POW_W-1:0]         px;
        logic [POW_W-1:0]         py;
    } term_t;

    typedef struct packed {
        logic       latch;
        logic [2:0] idx_op;
        logic [1:0] rd_sel;
        logic [1:0] wr_sel;
        logic       term_load;
        logic       mul_x;
        logic       mul_y;
        logic       acc;
        logic       sum_clr;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       respond;
        logic       reject;
    } dp_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             ins_bad;
        logic             del_bad;
        logic             idx_gt_pos;
        logic             idx_next_lt_cnt;
        logic             idx_lt_cnt;
        logic             ex_zero;
        logic             ey_zero;
    } dp_stat_t;

endpackage

/* rtl/bptt_ctrl.sv */
// Sequencer for insert, delete and evaluate commands.
module bptt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bptt_pkg::dp_stat_t  stat,
    output bptt_pkg::dp_ctrl_t  ctrl
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_INS_CHK = 4'd2;
    localparam logic [3:0] S_INS_WR  = 4'd3;
    localparam logic [3:0] S_DEL_CHK = 4'd4;
    localparam logic [3:0] S_DEL_WR  = 4'd5;
    localparam logic [3:0] S_EV_CHK  = 4'd6;
    localparam logic [3:0] S_EV_LOAD = 4'd7;
    localparam logic [3:0] S_EV_MX   = 4'd8;
    localparam logic [3:0] S_EV_MY   = 4'd9;
    localparam logic [3:0] S_FIN     = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.latch = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                priority if (stat.cmd == bptt_pkg::CMD_INSERT && !stat.ins_bad)
                begin
                    ctrl.idx_op = bptt_pkg::IDX_COUNT;
                    state_next  = S_INS_CHK;
                end
                else if (stat.cmd == bptt_pkg::CMD_DELETE && !stat.del_bad)
                begin
                    ctrl.idx_op = bptt_pkg::IDX_POS;
                    state_next  = S_DEL_CHK;
                end
                else if (stat.cmd == bptt_pkg::CMD_EVAL)
                begin
                    ctrl.idx_op  = bptt_pkg::IDX_ZERO;
                    ctrl.sum_clr = 1'b1;
                    state_next   = S_EV_CHK;
                end
                else
                begin
                    ctrl.respond = 1'b1;
                    ctrl.reject  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_INS_CHK:
            begin
                if (stat.idx_gt_pos)
                begin
                    ctrl.rd_sel = bptt_pkg::RD_PREV;
                    state_next  = S_INS_WR;
                end
                else
                begin
                    ctrl.wr_sel  = bptt_pkg::WR_NEW;
                    ctrl.cnt_inc = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_INS_WR:
            begin
                ctrl.wr_sel = bptt_pkg::WR_MOVED;
                ctrl.idx_op = bptt_pkg::IDX_DEC;
                state_next  = S_INS_CHK;
            end
            S_DEL_CHK:
            begin
                if (stat.idx_next_lt_cnt)
                begin
                    ctrl.rd_sel = bptt_pkg::RD_NEXT;
                    state_next  = S_DEL_WR;
                end
                else
                begin
                    ctrl.cnt_dec = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_DEL_WR:
            begin
                ctrl.wr_sel = bptt_pkg::WR_MOVED;
                ctrl.idx_op = bptt_pkg::IDX_INC;
                state_next  = S_DEL_CHK;
            end
            S_EV_CHK:
            begin
                if (stat.idx_lt_cnt)
                begin
                    ctrl.rd_sel = bptt_pkg::RD_CUR;
                    state_next  = S_EV_LOAD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_EV_LOAD:
            begin
                ctrl.term_load = 1'b1;
                state_next     = S_EV_MX;
            end
            S_EV_MX:
            begin
                if (stat.ex_zero)
                begin
                    state_next = S_EV_MY;
                end
                else
                begin
                    ctrl.mul_x = 1'b1;
                end
            end
            S_EV_MY:
            begin
                if (stat.ey_zero)
                begin
                    ctrl.acc    = 1'b1;
                    ctrl.idx_op = bptt_pkg::IDX_INC;
                    state_next  = S_EV_CHK;
                end
                else
                begin
                    ctrl.mul_y = 1'b1;
                end
            end
            S_FIN:
            begin
                ctrl.respond = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/bptt_dp.sv */
// Datapath: term memory, index and count, power multiplier and accumulator.
module bptt_dp (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  bptt_pkg::dp_ctrl_t                       ctrl,
    output bptt_pkg::dp_stat_t                       stat,
    input  logic [bptt_pkg::CMD_W-1:0]               command,
    input  logic [bptt_pkg::POS_W-1:0]               position,
    input  logic                                     negate_term,
    input  logic signed [bptt_pkg::COEF_W-1:0]       coefficient,
    input  logic [bptt_pkg::POW_W-1:0]               x_power,
    input  logic [bptt_pkg::POW_W-1:0]               y_power,
    input  logic signed [bptt_pkg::VAL_W-1:0]        x_value,
    input  logic signed [bptt_pkg::VAL_W-1:0]        y_value,
    output logic                                     done,
    output logic                                     status,
    output logic signed [bptt_pkg::SUM_W-1:0]        sum,
    output logic [bptt_pkg::CNT_W-1:0]               term_count
);

    localparam int CW = bptt_pkg::CNT_W;
    localparam int SW = bptt_pkg::SUM_W;

    bptt_pkg::term_t              mem [bptt_pkg::MAX_TERMS];
    bptt_pkg::term_t              rd_data_reg;

    logic [bptt_pkg::CMD_W-1:0]   cmd_reg;
    logic [bptt_pkg::POS_W-1:0]   pos_reg;
    bptt_pkg::term_t              new_term_reg;
    logic [SW-1:0]                xv_reg;
    logic [SW-1:0]                yv_reg;

    logic [CW-1:0]                cnt_reg;
    logic [CW-1:0]                idx_reg;
    logic [CW-1:0]                idx_next;
    logic [CW-1:0]                idx_prev;
    logic [CW-1:0]                idx_plus;
    logic [CW-1:0]                rd_addr;

    logic [SW-1:0]                prod_reg;
    logic [SW-1:0]                mul_op;
    logic [bptt_pkg::POW_W-1:0]   ex_reg;
    logic [bptt_pkg::POW_W-1:0]   ey_reg;
    logic                         neg_reg;
    logic [SW-1:0]                acc_reg;

    logic                         done_reg;
    logic                         status_reg;
    logic [SW-1:0]                sum_reg;

    assign idx_prev = idx_reg - CW'(1);
    assign idx_plus = idx_reg + CW'(1);

    // operand capture at command accept
    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            cmd_reg           <= command;
            pos_reg           <= position;
            new_term_reg.neg  <= negate_term;
            new_term_reg.coef <= coefficient;
            new_term_reg.px   <= x_power;
            new_term_reg.py   <= y_power;
            xv_reg            <= SW'(x_value);
            yv_reg            <= SW'(y_value);
        end
    end

    always_comb
    begin
        unique case (ctrl.idx_op)
            bptt_pkg::IDX_COUNT: idx_next = cnt_reg;
            bptt_pkg::IDX_POS:   idx_next = CW'(pos_reg);
            bptt_pkg::IDX_ZERO:  idx_next = '0;
            bptt_pkg::IDX_DEC:   idx_next = idx_prev;
            bptt_pkg::IDX_INC:   idx_next = idx_plus;
            default:             idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (ctrl.cnt_inc)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (ctrl.cnt_dec)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_comb
    begin
        unique case (ctrl.rd_sel)
            bptt_pkg::RD_PREV: rd_addr = idx_prev;
            bptt_pkg::RD_NEXT: rd_addr = idx_plus;
            default:           rd_addr = idx_reg;
        endcase
    end

    // term memory: one read port with registered data, one write port
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_sel != bptt_pkg::RD_NONE)
        begin
            rd_data_reg <= mem[rd_addr[bptt_pkg::IDX_W-1:0]];
        end
        if (ctrl.wr_sel == bptt_pkg::WR_MOVED)
        begin
            mem[idx_reg[bptt_pkg::IDX_W-1:0]] <= rd_data_reg;
        end
        else if (ctrl.wr_sel == bptt_pkg::WR_NEW)
        begin
            mem[idx_reg[bptt_pkg::IDX_W-1:0]] <= new_term_reg;
        end
    end

    // one multiply per cycle, low 32 bits kept
    assign mul_op = ctrl.mul_y ? yv_reg : xv_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.term_load)
        begin
            prod_reg <= SW'(rd_data_reg.coef);
            ex_reg   <= rd_data_reg.px;
            ey_reg   <= rd_data_reg.py;
            neg_reg  <= rd_data_reg.neg;
        end
        else if (ctrl.mul_x)
        begin
            prod_reg <= prod_reg * mul_op;
            ex_reg   <= ex_reg - bptt_pkg::POW_W'(1);
        end
        else if (ctrl.mul_y)
        begin
            prod_reg <= prod_reg * mul_op;
            ey_reg   <= ey_reg - bptt_pkg::POW_W'(1);
        end
        if (ctrl.sum_clr)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc)
        begin
            acc_reg <= neg_reg ? (acc_reg - prod_reg) : (acc_reg + prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            status_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.respond;
            if (ctrl.respond)
            begin
                status_reg <= ctrl.reject;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.respond)
        begin
            sum_reg <= (!ctrl.reject && cmd_reg == bptt_pkg::CMD_EVAL) ? acc_reg : '0;
        end
    end

    // powers are 4 bits wide, so they never exceed the power limit
    assign stat.cmd             = cmd_reg;
    assign stat.ins_bad         = (CW'(pos_reg) > cnt_reg) || (pos_reg > CW'(bptt_pkg::MAX_TERMS))
                                  || (cnt_reg >= CW'(bptt_pkg::MAX_TERMS));
    assign stat.del_bad         = (pos_reg >= bptt_pkg::POS_W'(cnt_reg));
    assign stat.idx_gt_pos      = (idx_reg > CW'(pos_reg));
    assign stat.idx_next_lt_cnt = ({1'b0, idx_reg} + (CW+1)'(1)) < {1'b0, cnt_reg};
    assign stat.idx_lt_cnt      = (idx_reg < cnt_reg);
    assign stat.ex_zero         = (ex_reg == '0);
    assign stat.ey_zero         = (ey_reg == '0);

    assign done       = done_reg;
    assign status     = status_reg;
    assign sum        = sum_reg;
    assign term_count = cnt_reg;

endmodule

/* rtl/bivariate_polynomial_term_table.sv */
// Top level of the bivariate polynomial term table.
//
// Command channel: a word (command, position, term fields, x_value, y_value)
// is taken at a rising edge with start high and busy low. busy stays high
// until the result is out; start is ignored while busy.
// Result channel: done is high for exactly one cycle with status, sum and
// term_count valid; the receiver must take it then.
// Rejected commands respond straight from dispatch. An insert moves the
// entries from the end down to position p up by one place, then writes
// the new term at p; a delete moves the entries above p down by one place.
// An evaluation walks every term, multiplies its coefficient by x_value px
// times and by y_value py times, and adds or subtracts the product.
// Evaluation runs one 32-bit multiply per cycle per power step; inserts and
// deletes move one table entry at a time, each read and then written back.
// A new command may be accepted in the cycle that done is high.
// Reset clears the term count; table contents are left as they are.
module bivariate_polynomial_term_table (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic [bptt_pkg::CMD_W-1:0]               command,
    input  logic [bptt_pkg::POS_W-1:0]               position,
    input  logic                                     negate_term,
    input  logic signed [bptt_pkg::COEF_W-1:0]       coefficient,
    input  logic [bptt_pkg::POW_W-1:0]               x_power,
    input  logic [bptt_pkg::POW_W-1:0]               y_power,
    input  logic signed [bptt_pkg::VAL_W-1:0]        x_value,
    input  logic signed [bptt_pkg::VAL_W-1:0]        y_value,
    output logic                                     done,
    output logic                                     status,
    output logic signed [bptt_pkg::SUM_W-1:0]        sum,
    output logic [bptt_pkg::CNT_W-1:0]               term_count
);

    bptt_pkg::dp_ctrl_t ctrl;
    bptt_pkg::dp_stat_t stat;

    bptt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    bptt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .command     (command),
        .position    (position),
        .negate_term (negate_term),
        .coefficient (coefficient),
        .x_power     (x_power),
        .y_power     (y_power),
        .x_value     (x_value),
        .y_value     (y_value),
        .done        (done),
        .status      (status),
        .sum         (sum),
        .term_count  (term_count)
    );

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result issued while still busy");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        term_count <= bptt_pkg::CNT_W'(bptt_pkg::MAX_TERMS))
        else $error("term count beyond table size");

    a_reject_sum: assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> sum == '0)
        else $error("rejected word returned a nonzero sum");
`endif

endmodule

/* tb/sv/tb_bivariate_polynomial_term_table.sv */
// Self-checking testbench for the bivariate polynomial term table.
module tb_bivariate_polynomial_term_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [bptt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic             ST_DONE    = 1'b0;
    localparam logic             ST_REJECT  = 1'b1;
    localparam int               ITEMS_PER_PHASE = 310;
    localparam int               DRAIN_CYCLES    = 600;

    // Scoreboard: mirrors the term table and keeps the outcomes still owed.
    class term_table_scoreboard;
        typedef struct packed {
            logic                       status;
            logic [bptt_pkg::SUM_W-1:0] sum;
            logic [bptt_pkg::CNT_W-1:0] count;
        } outcome_t;

        bptt_pkg::term_t terms[bptt_pkg::MAX_TERMS];
        int unsigned     held;
        outcome_t        expected_outcomes[$];
        int unsigned     errors;

        function new();
            held = 0;
            errors = 0;
        endfunction

        function logic [bptt_pkg::SUM_W-1:0] raise(logic [bptt_pkg::SUM_W-1:0] base,
                                                   logic [bptt_pkg::POW_W-1:0] exponent);
            logic [bptt_pkg::SUM_W-1:0] acc;
            acc = bptt_pkg::SUM_W'(1);
            for (int i = 0; i < exponent; i++)
                acc = acc * base;
            return acc;
        endfunction

        function void note_command(logic [bptt_pkg::CMD_W-1:0] cmd,
                                   logic [bptt_pkg::POS_W-1:0] pos,
                                   logic neg, logic [bptt_pkg::COEF_W-1:0] coef,
                                   logic [bptt_pkg::POW_W-1:0] px,
                                   logic [bptt_pkg::POW_W-1:0] py,
                                   logic [bptt_pkg::VAL_W-1:0] xv,
                                   logic [bptt_pkg::VAL_W-1:0] yv);
            outcome_t                   want;
            logic [bptt_pkg::SUM_W-1:0] xw;
            logic [bptt_pkg::SUM_W-1:0] yw;
            logic [bptt_pkg::SUM_W-1:0] part;
            want.status = ST_DONE;
            want.sum = '0;
            xw = {{(bptt_pkg::SUM_W-bptt_pkg::VAL_W){xv[bptt_pkg::VAL_W-1]}}, xv};
            yw = {{(bptt_pkg::SUM_W-bptt_pkg::VAL_W){yv[bptt_pkg::VAL_W-1]}}, yv};
            case (cmd)
                bptt_pkg::CMD_INSERT:
                begin
                    if (pos > held || held >= bptt_pkg::MAX_TERMS)
                        want.status = ST_REJECT;
                    else
                    begin
                        for (int i = held; i > pos; i--)
                            terms[i] = terms[i-1];
                        terms[pos].neg = neg;
                        terms[pos].coef = coef;
                        terms[pos].px = px;
                        terms[pos].py = py;
                        held++;
                    end
                end
                bptt_pkg::CMD_DELETE:
                begin
                    if (pos >= held)
                        want.status = ST_REJECT;
                    else
                    begin
                        for (int i = pos; i + 1 < held; i++)
                            terms[i] = terms[i+1];
                        held--;
                    end
                end
                bptt_pkg::CMD_EVAL:
                begin
                    for (int i = 0; i < held; i++)
                    begin
                        part = {{(bptt_pkg::SUM_W-bptt_pkg::COEF_W)
                                 {terms[i].coef[bptt_pkg::COEF_W-1]}}, terms[i].coef};
                        part = part * raise(xw, terms[i].px) * raise(yw, terms[i].py);
                        if (terms[i].neg)
                            part = -part;
                        want.sum = want.sum + part;
                    end
                end
                default:
                    want.status = ST_REJECT;
            endcase
            want.count = held[bptt_pkg::CNT_W-1:0];
            expected_outcomes.push_back(want);
        endfunction

        function void check_outcome(logic st, logic [bptt_pkg::SUM_W-1:0] sm,
                                    logic [bptt_pkg::CNT_W-1:0] cnt);
            outcome_t want;
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t: unexpected word: status %0d sum %0h term_count %0d",
                         $time, st, sm, cnt);
                errors++;
                return;
            end
            want = expected_outcomes.pop_front();
            if (st !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
                errors++;
            end
            if (sm !== want.sum)
            begin
                $display("%0t: sum expected %0h actual %0h", $time, want.sum, sm);
                errors++;
            end
            if (cnt !== want.count)
            begin
                $display("%0t: term_count expected %0d actual %0d", $time, want.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [bptt_pkg::CMD_W-1:0]         command;
    logic [bptt_pkg::POS_W-1:0]         position;
    logic                               negate_term;
    logic signed [bptt_pkg::COEF_W-1:0] coefficient;
    logic [bptt_pkg::POW_W-1:0]         x_power;
    logic [bptt_pkg::POW_W-1:0]         y_power;
    logic signed [bptt_pkg::VAL_W-1:0]  x_value;
    logic signed [bptt_pkg::VAL_W-1:0]  y_value;
    logic                               done;
    logic                               status;
    logic signed [bptt_pkg::SUM_W-1:0]  sum;
    logic [bptt_pkg::CNT_W-1:0]         term_count;

    term_table_scoreboard sb;
    int unsigned          idle_pct;

    bivariate_polynomial_term_table DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .position    (position),
        .negate_term (negate_term),
        .coefficient (coefficient),
        .x_power     (x_power),
        .y_power     (y_power),
        .x_value     (x_value),
        .y_value     (y_value),
        .done        (done),
        .status      (status),
        .sum         (sum),
        .term_count  (term_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #25_000_000;
        $display("tb_bivariate_polynomial_term_table: errors");
        $finish;
    end

    // result of the previous word is checked before the word taken at this edge is noted
    always @(posedge clk)
    begin
        if (done)
            sb.check_outcome(status, sum, term_count);
        if (start && !busy)
            sb.note_command(command, position, negate_term, coefficient,
                            x_power, y_power, x_value, y_value);
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic [bptt_pkg::CMD_W-1:0] cmd,
                             input logic [bptt_pkg::POS_W-1:0] pos,
                             input logic neg, input logic [bptt_pkg::COEF_W-1:0] coef,
                             input logic [bptt_pkg::POW_W-1:0] px,
                             input logic [bptt_pkg::POW_W-1:0] py,
                             input logic [bptt_pkg::VAL_W-1:0] xv,
                             input logic [bptt_pkg::VAL_W-1:0] yv);
        logic taken;
        command = cmd;
        position = pos;
        negate_term = neg;
        coefficient = coef;
        x_power = px;
        y_power = py;
        x_value = xv;
        y_value = yv;
        taken = 1'b0;
        while (!taken)
        begin
            start = ($urandom_range(99, 0) >= idle_pct);
            @(posedge clk);
            taken = start && !busy;
            @(negedge clk);
        end
    endtask

    function automatic logic [bptt_pkg::VAL_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 45)
            return bptt_pkg::VAL_W'($signed($urandom_range(6, 0)) - 3);
        if (r < 55)
            return ($urandom_range(1, 0) != 0) ? 16'h8000 : 16'h7fff;
        return bptt_pkg::VAL_W'($urandom_range(16'hffff, 0));
    endfunction

    task automatic random_word(input int unsigned mode);
        int unsigned                ins_w;
        int unsigned                del_w;
        int unsigned                r;
        logic [bptt_pkg::CMD_W-1:0] cmd;
        logic [bptt_pkg::POS_W-1:0] pos;
        logic [bptt_pkg::POW_W-1:0] px;
        logic [bptt_pkg::POW_W-1:0] py;
        // mode 0 fills the table, 1 mixes, 2 drains
        ins_w = (mode == 0) ? 70 : (mode == 1) ? 40 : 15;
        del_w = (mode == 0) ? 10 : (mode == 1) ? 25 : 55;
        r = $urandom_range(99, 0);
        if (r < 4)
            cmd = CMD_UNUSED;
        else if (r < 4 + ins_w)
            cmd = bptt_pkg::CMD_INSERT;
        else if (r < 4 + ins_w + del_w)
            cmd = bptt_pkg::CMD_DELETE;
        else
            cmd = bptt_pkg::CMD_EVAL;
        if ($urandom_range(99, 0) < 15)
            pos = bptt_pkg::POS_W'($urandom_range(31, 0));
        else if (cmd == bptt_pkg::CMD_DELETE)
            pos = (sb.held > 0) ? bptt_pkg::POS_W'($urandom_range(sb.held - 1, 0)) : '0;
        else
            pos = bptt_pkg::POS_W'($urandom_range(sb.held, 0));
        px = ($urandom_range(1, 0) != 0) ? bptt_pkg::POW_W'($urandom_range(3, 0))
                                         : bptt_pkg::POW_W'($urandom_range(15, 0));
        py = ($urandom_range(1, 0) != 0) ? bptt_pkg::POW_W'($urandom_range(3, 0))
                                         : bptt_pkg::POW_W'($urandom_range(15, 0));
        send_word(cmd, pos, 1'($urandom_range(1, 0)), pick_value(), px, py,
                  pick_value(), pick_value());
    endtask

    initial
    begin
        int unsigned mode;
        sb = new();
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        command = bptt_pkg::CMD_INSERT;
        position = '0;
        negate_term = 1'b0;
        coefficient = '0;
        x_power = '0;
        y_power = '0;
        x_value = '0;
        y_value = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty table, bad positions
        send_word(bptt_pkg::CMD_EVAL,   5'd0,  1'b1, 16'hffff, 4'hf, 4'hf, 16'h0000, 16'h0000);
        send_word(bptt_pkg::CMD_DELETE, 5'd0,  1'b1, 16'hffff, 4'hf, 4'hf, 16'hffff, 16'hffff);
        send_word(bptt_pkg::CMD_INSERT, 5'd1,  1'b0, 16'h1234, 4'h1, 4'h1, 16'h0000, 16'h0000);
        // insert at head, head, tail, middle, then at a bad position
        send_word(bptt_pkg::CMD_INSERT, 5'd0,  1'b0, 16'h7fff, 4'hf, 4'h0, 16'h0000, 16'h0000);
        send_word(bptt_pkg::CMD_INSERT, 5'd0,  1'b1, 16'h8000, 4'h0, 4'hf, 16'hffff, 16'hffff);
        send_word(bptt_pkg::CMD_INSERT, 5'd2,  1'b0, 16'hffff, 4'hf, 4'hf, 16'h0000, 16'h0000);
        send_word(bptt_pkg::CMD_INSERT, 5'd1,  1'b1, 16'h0000, 4'h0, 4'h0, 16'h0000, 16'h0000);
        send_word(bptt_pkg::CMD_INSERT, 5'd31, 1'b0, 16'h0001, 4'h2, 4'h2, 16'h0000, 16'h0000);
        // extreme evaluation points, then an unused command
        send_word(bptt_pkg::CMD_EVAL,   5'd0,  1'b0, 16'h0000, 4'h0, 4'h0, 16'h8000, 16'h7fff);
        send_word(bptt_pkg::CMD_EVAL,   5'd31, 1'b1, 16'hffff, 4'hf, 4'hf, 16'h7fff, 16'h8000);
        send_word(bptt_pkg::CMD_EVAL,   5'd0,  1'b0, 16'h0000, 4'h0, 4'h0, 16'hffff, 16'hffff);
        send_word(bptt_pkg::CMD_EVAL,   5'd0,  1'b0, 16'h0000, 4'h0, 4'h0, 16'h0000, 16'h0000);
        send_word(CMD_UNUSED,           5'd0,  1'b1, 16'hffff, 4'hf, 4'hf, 16'h1111, 16'h2222);
        // deletes: out of range, one past the end, middle, head, tail, last entry
        send_word(bptt_pkg::CMD_DELETE, 5'd31, 1'b0, 16'h0000, 4'h0, 4'h0, 16'h0000, 16'h0000);
        send_word(bptt_pkg::CMD_DELETE, 5'd4,  1'b0, 16'h0000, 4'h0, 4'h0, 16'h0000, 16'h0000);
        send_word(bptt_pkg::CMD_DELETE, 5'd1,  1'b0, 16'h0000, 4'h0, 4'h0, 16'h0000, 16'h0000);
        send_word(bptt_pkg::CMD_EVAL,   5'd0,  1'b0, 16'h0000, 4'h0, 4'h0, 16'h0002, 16'h0003);
        send_word(bptt_pkg::CMD_DELETE, 5'd0,  1'b0, 16'h0000, 4'h0, 4'h0, 16'h0000, 16'h0000);
        send_word(bptt_pkg::CMD_DELETE, 5'd1,  1'b0, 16'h0000, 4'h0, 4'h0, 16'h0000, 16'h0000);
        send_word(bptt_pkg::CMD_DELETE, 5'd0,  1'b0, 16'h0000, 4'h0, 4'h0, 16'h0000, 16'h0000);
        send_word(bptt_pkg::CMD_EVAL,   5'd0,  1'b0, 16'h0000, 4'h0, 4'h0, 16'h0005, 16'h0005);

        mode = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 15 : (phase == 1) ? 74 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(39, 0) == 0)
                    mode = $urandom_range(2, 0);
                random_word(mode);
            end
        end
        start = 1'b0;

        while (sb.expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_bivariate_polynomial_term_table: clean");
        else
            $display("tb_bivariate_polynomial_term_table: errors");
        $finish;
    end

endmodule
